[rtl/tda_pkg.sv]
package tda_pkg;

  localparam int unsigned AMOUNT_BITS_DEFAULT = 20;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic [1:0] UNIT_SEC  = 2'd0;
  localparam logic [1:0] UNIT_MIN  = 2'd1;
  localparam logic [1:0] UNIT_HOUR = 2'd2;

  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned MIN_PER_HOUR  = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned HOUR_MAX      = 23;
  localparam int unsigned MINUTE_MAX    = 59;
  localparam int unsigned DAYS_MAX      = 65535;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] unit;
    logic [4:0] dh;
    logic [5:0] dm;
    logic [5:0] ds;
    logic [4:0] lh;
    logic [5:0] lm;
    logic [5:0] ls;
  } tda_item_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] days;
    logic        err;
  } tda_result_t;

endpackage

[rtl/tda_const_div.sv]
module tda_const_div #(
  parameter int unsigned W   = 20,
  parameter int unsigned DIV = 60,
  parameter int unsigned RW  = $clog2(DIV)
) (
  input  logic [W-1:0]  x,
  output logic [W-1:0]  q,
  output logic [RW-1:0] r
);

  localparam logic [W-1:0] RECIP = W'((64'd1 << W) / 64'(DIV));

  logic [2*W-1:0] prod;
  logic [W-1:0]   q_est;
  logic [W-1:0]   back;
  logic [W-1:0]   rem;

  assign prod  = (2*W)'(x) * (2*W)'(RECIP);
  assign q_est = prod[2*W-1:W];
  assign back  = W'(q_est * W'(DIV));
  assign rem   = x - back;

  always_comb begin
    if (rem >= W'(DIV)) begin
      q = q_est + W'(1);
      r = RW'(rem - W'(DIV));
    end else begin
      q = q_est;
      r = RW'(rem);
    end
  end

endmodule

[rtl/tda_clock_core.sv]
module tda_clock_core import tda_pkg::*; #(
  parameter int unsigned AMOUNT_BITS = AMOUNT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  tda_item_t              item,
  input  logic [AMOUNT_BITS-1:0] day_quot,
  output tda_result_t            result
);

  logic [4:0] hours, hours_next;
  logic [5:0] minutes, minutes_next;
  logic [5:0] seconds, seconds_next;

  logic [6:0] s_sum, m_sum, m_need;
  logic [5:0] h_sum, h_need;
  logic       c0, c1, c2, b0, b1, b2;
  logic [4:0] add_h, sub_h;
  logic [5:0] add_m, add_s, sub_m, sub_s;
  logic [33:0] days_wide;
  logic [15:0] days;
  logic        err;
  logic        load_ok;

  assign s_sum = 7'(seconds) + 7'(item.ds);
  assign c0    = s_sum >= 7'(SEC_PER_MIN);
  assign add_s = 6'(c0 ? s_sum - 7'(SEC_PER_MIN) : s_sum);
  assign m_sum = 7'(minutes) + 7'(item.dm) + 7'(c0);
  assign c1    = m_sum >= 7'(MIN_PER_HOUR);
  assign add_m = 6'(c1 ? m_sum - 7'(MIN_PER_HOUR) : m_sum);
  assign h_sum = 6'(hours) + 6'(item.dh) + 6'(c1);
  assign c2    = h_sum >= 6'(HOURS_PER_DAY);
  assign add_h = 5'(c2 ? h_sum - 6'(HOURS_PER_DAY) : h_sum);

  assign b0     = seconds < item.ds;
  assign sub_s  = 6'(7'(seconds) + (b0 ? 7'(SEC_PER_MIN) : 7'd0) - 7'(item.ds));
  assign m_need = 7'(item.dm) + 7'(b0);
  assign b1     = 7'(minutes) < m_need;
  assign sub_m  = 6'(7'(minutes) + (b1 ? 7'(MIN_PER_HOUR) : 7'd0) - m_need);
  assign h_need = 6'(item.dh) + 6'(b1);
  assign b2     = 6'(hours) < h_need;
  assign sub_h  = 5'(6'(hours) + (b2 ? 6'(HOURS_PER_DAY) : 6'd0) - h_need);

  assign load_ok = (item.lh <= 5'(HOUR_MAX)) && (item.lm <= 6'(MINUTE_MAX))
                   && (item.ls <= 6'(MINUTE_MAX));

  always_comb begin
    hours_next   = hours;
    minutes_next = minutes;
    seconds_next = seconds;
    days_wide    = '0;
    err          = 1'b0;
    case (item.op)
      OP_LOAD: begin
        if (load_ok) begin
          hours_next   = item.lh;
          minutes_next = item.lm;
          seconds_next = item.ls;
        end else begin
          err = 1'b1;
        end
      end
      OP_ADD: begin
        if (item.unit inside {UNIT_SEC, UNIT_MIN, UNIT_HOUR}) begin
          hours_next   = add_h;
          minutes_next = add_m;
          seconds_next = add_s;
          days_wide    = 34'(day_quot) + 34'(c2);
        end
      end
      OP_SUB: begin
        if (item.unit inside {UNIT_SEC, UNIT_MIN, UNIT_HOUR}) begin
          hours_next   = sub_h;
          minutes_next = sub_m;
          seconds_next = sub_s;
          days_wide    = 34'(day_quot) + 34'(b2);
        end
      end
      default: ;
    endcase
  end

  assign days = (days_wide > 34'(DAYS_MAX)) ? 16'(DAYS_MAX) : days_wide[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hours   <= '0;
      minutes <= '0;
      seconds <= '0;
    end else if (en) begin
      hours   <= hours_next;
      minutes <= minutes_next;
      seconds <= seconds_next;
    end
  end

  assign result.hour   = hours_next;
  assign result.minute = minutes_next;
  assign result.second = seconds_next;
  assign result.days   = days;
  assign result.err    = err;

endmodule

[rtl/time_of_day_adjuster.sv]
// Time of day adjuster: holds hour, minute and second and applies one command per word.
// Input channel: in_valid / in_stall with operation, unit, amount and load fields.
// A word is taken at a clock edge with in_valid high and in_stall low.
// Operations: add or subtract amount in seconds, minutes or hours, or load a time.
// An invalid load leaves the time unchanged and returns load_error.
// Output channel: out_valid / out_stall with the time after the command,
// days carried or borrowed (saturating at 65535) and load_error.
// A taken word moves through stage registers s1 to s4, then into the output register.
// Throughput: one word per cycle unless the output stalls; three divide-by-constant
// stages split the amount into days, hours, minutes and seconds, and a final stage runs
// the carry or borrow chain against the held time, which updates in that same cycle.
// A stalled output holds; earlier stages keep filling their empty slots and
// in_stall rises only when every stage holds a word.
// Reset (synchronous, rst high) sets the time to 00:00:00 and empties the pipeline.
module time_of_day_adjuster import tda_pkg::*; #(
  parameter int unsigned AMOUNT_BITS = AMOUNT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             operation,
  input  logic [1:0]             unit,
  input  logic [AMOUNT_BITS-1:0] amount,
  input  logic [4:0]             load_hour,
  input  logic [5:0]             load_minute,
  input  logic [5:0]             load_second,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [4:0]             hour_now,
  output logic [5:0]             minute_now,
  output logic [5:0]             second_now,
  output logic [15:0]            days_carried,
  output logic                   load_error
);

  localparam int unsigned W = AMOUNT_BITS;

  logic v1, v2, v3, v4;
  logic load1, load2, load3, load4, adv_o;
  tda_item_t s1_item, s2_item, s3_item, s4_item;
  tda_item_t s2_item_next, s3_item_next, s4_item_next;
  logic [W-1:0] s1_amt, s2_mtot, s3_htot, s4_quot;

  logic [W-1:0] q1, q2, q3;
  logic [5:0]   r1, r2;
  logic [4:0]   r3;
  tda_result_t  core_res;

  assign adv_o    = !out_valid || !out_stall;
  assign load4    = !v4 || adv_o;
  assign load3    = !v3 || load4;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign in_stall = !load1;

  tda_const_div #(.W(W), .DIV(SEC_PER_MIN)) u_div_sec (
    .x(s1_amt), .q(q1), .r(r1)
  );

  tda_const_div #(.W(W), .DIV(MIN_PER_HOUR)) u_div_min (
    .x(s2_mtot), .q(q2), .r(r2)
  );

  tda_const_div #(.W(W), .DIV(HOURS_PER_DAY)) u_div_hour (
    .x(s3_htot), .q(q3), .r(r3)
  );

  tda_clock_core #(.AMOUNT_BITS(W)) u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (v4 && adv_o),
    .item    (s4_item),
    .day_quot(s4_quot),
    .result  (core_res)
  );

  always_comb begin
    s2_item_next    = s1_item;
    s2_item_next.ds = (s1_item.unit == UNIT_SEC) ? r1 : 6'd0;
    s3_item_next    = s2_item;
    s3_item_next.dm = (s2_item.unit == UNIT_HOUR) ? 6'd0 : r2;
    s4_item_next    = s3_item;
    s4_item_next.dh = r3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load1) v1 <= in_valid;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) v4 <= v3;
      if (adv_o) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_item.op   <= operation;
      s1_item.unit <= unit;
      s1_item.dh   <= '0;
      s1_item.dm   <= '0;
      s1_item.ds   <= '0;
      s1_item.lh   <= load_hour;
      s1_item.lm   <= load_minute;
      s1_item.ls   <= load_second;
      s1_amt       <= amount;
    end
    if (load2) begin
      s2_item    <= s2_item_next;
      s2_mtot    <= (s1_item.unit == UNIT_SEC) ? q1 : s1_amt;
    end
    if (load3) begin
      s3_item    <= s3_item_next;
      s3_htot    <= (s2_item.unit == UNIT_HOUR) ? s2_mtot : q2;
    end
    if (load4) begin
      s4_item    <= s4_item_next;
      s4_quot    <= q3;
    end
    if (adv_o) begin
      hour_now     <= core_res.hour;
      minute_now   <= core_res.minute;
      second_now   <= core_res.second;
      days_carried <= core_res.days;
      load_error   <= core_res.err;
    end
  end

`ifndef SYNTH
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour_now < 5'd24) && (minute_now < 6'd60) && (second_now < 6'd60))
    else $error("time out of range");

  a_err_no_days: assert property (@(posedge clk) disable iff (rst)
    out_valid && load_error |-> days_carried == 16'd0)
    else $error("load error with nonzero day count");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted word not captured");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !adv_o |=> v4 && $stable(s4_item) && $stable(s4_quot))
    else $error("final stage changed while output stalled");
`endif

endmodule

[verif/tb_time_of_day_adjuster.sv]
module tb_time_of_day_adjuster;
  import tda_pkg::*;

  localparam int unsigned AW = AMOUNT_BITS_DEFAULT;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] UNIT_NONE = 2'd3;
  localparam logic [AW-1:0] AMT_MAX = {AW{1'b1}};
  localparam longint unsigned SECS_HOUR = SEC_PER_MIN * MIN_PER_HOUR;
  localparam longint unsigned SECS_DAY = SECS_HOUR * HOURS_PER_DAY;
  localparam int N_DIR = 25;
  localparam int N_RAND = 1775;

  typedef struct packed {
    logic [1:0]    op;
    logic [1:0]    unit;
    logic [AW-1:0] amount;
    logic [4:0]    lh;
    logic [5:0]    lm;
    logic [5:0]    ls;
  } tod_cmd_t;

  typedef struct packed {
    tod_cmd_t    cmd;
    logic        typed;
    tda_result_t want;
  } tod_row_t;

  localparam tda_result_t NO_WANT = '0;

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    operation = OP_ADD;
  logic [1:0]    unit = UNIT_SEC;
  logic [AW-1:0] amount = '0;
  logic [4:0]    load_hour = '0;
  logic [5:0]    load_minute = '0;
  logic [5:0]    load_second = '0;
  logic          out_valid;
  logic          out_stall = 1'b1;
  logic [4:0]    hour_now;
  logic [5:0]    minute_now;
  logic [5:0]    second_now;
  logic [15:0]   days_carried;
  logic          load_error;

  logic [4:0] tod_hour;
  logic [5:0] tod_minute;
  logic [5:0] tod_second;

  tda_result_t pending_times[$];
  int n_errors = 0;
  int n_words = 0;
  int n_add = 0;
  int n_sub = 0;
  int n_load = 0;
  int n_refused = 0;
  int n_other = 0;
  int n_day_moves = 0;

  tod_row_t steps_table [N_DIR] = '{
    '{'{OP_ADD,  UNIT_SEC,  20'd0,     5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd0,  6'd0,  16'd0,     1'b0}},
    '{'{OP_SUB,  UNIT_SEC,  20'd1,     5'd0,  6'd0,  6'd0},  1'b1, '{5'd23, 6'd59, 6'd59, 16'd1,     1'b0}},
    '{'{OP_ADD,  UNIT_SEC,  20'd1,     5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd0,  6'd0,  16'd1,     1'b0}},
    '{'{OP_LOAD, UNIT_SEC,  20'd0,     5'd23, 6'd59, 6'd59}, 1'b1, '{5'd23, 6'd59, 6'd59, 16'd0,     1'b0}},
    '{'{OP_LOAD, UNIT_SEC,  20'd0,     5'd24, 6'd0,  6'd0},  1'b1, '{5'd23, 6'd59, 6'd59, 16'd0,     1'b1}},
    '{'{OP_LOAD, UNIT_MIN,  20'd0,     5'd0,  6'd60, 6'd0},  1'b1, '{5'd23, 6'd59, 6'd59, 16'd0,     1'b1}},
    '{'{OP_LOAD, UNIT_HOUR, 20'd0,     5'd0,  6'd0,  6'd60}, 1'b1, '{5'd23, 6'd59, 6'd59, 16'd0,     1'b1}},
    '{'{OP_LOAD, UNIT_NONE, AMT_MAX,   5'd31, 6'd63, 6'd63}, 1'b1, '{5'd23, 6'd59, 6'd59, 16'd0,     1'b1}},
    '{'{OP_LOAD, UNIT_SEC,  20'd0,     5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd0,  6'd0,  16'd0,     1'b0}},
    '{'{OP_ADD,  UNIT_HOUR, AMT_MAX,   5'd0,  6'd0,  6'd0},  1'b1, '{5'd15, 6'd0,  6'd0,  16'd43690, 1'b0}},
    '{'{OP_SUB,  UNIT_HOUR, 20'd15,    5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd0,  6'd0,  16'd0,     1'b0}},
    '{'{OP_SUB,  UNIT_HOUR, 20'd24,    5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd0,  6'd0,  16'd1,     1'b0}},
    '{'{OP_SUB,  UNIT_MIN,  20'd60,    5'd0,  6'd0,  6'd0},  1'b1, '{5'd23, 6'd0,  6'd0,  16'd1,     1'b0}},
    '{'{OP_SUB,  UNIT_SEC,  AMT_MAX,   5'd0,  6'd0,  6'd0},  1'b0, NO_WANT},
    '{'{OP_ADD,  UNIT_MIN,  AMT_MAX,   5'd0,  6'd0,  6'd0},  1'b0, NO_WANT},
    '{'{OP_ADD,  UNIT_NONE, 20'd100,   5'd0,  6'd0,  6'd0},  1'b0, NO_WANT},
    '{'{OP_SUB,  UNIT_NONE, AMT_MAX,   5'd0,  6'd0,  6'd0},  1'b0, NO_WANT},
    '{'{OP_NONE, UNIT_SEC,  20'd500,   5'd31, 6'd63, 6'd63}, 1'b0, NO_WANT},
    '{'{OP_LOAD, UNIT_SEC,  20'd0,     5'd12, 6'd30, 6'd30}, 1'b1, '{5'd12, 6'd30, 6'd30, 16'd0,     1'b0}},
    '{'{OP_SUB,  UNIT_SEC,  20'd45030, 5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd0,  6'd0,  16'd0,     1'b0}},
    '{'{OP_SUB,  UNIT_MIN,  20'd1,     5'd0,  6'd0,  6'd0},  1'b1, '{5'd23, 6'd59, 6'd0,  16'd1,     1'b0}},
    '{'{OP_ADD,  UNIT_SEC,  20'd60,    5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd0,  6'd0,  16'd1,     1'b0}},
    '{'{OP_LOAD, UNIT_SEC,  20'd0,     5'd0,  6'd59, 6'd59}, 1'b1, '{5'd0,  6'd59, 6'd59, 16'd0,     1'b0}},
    '{'{OP_ADD,  UNIT_MIN,  20'd1440,  5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd59, 6'd59, 16'd1,     1'b0}},
    '{'{OP_SUB,  UNIT_MIN,  20'd59,    5'd0,  6'd0,  6'd0},  1'b1, '{5'd0,  6'd0,  6'd59, 16'd0,     1'b0}}
  };

  time_of_day_adjuster #(
    .AMOUNT_BITS(AW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .unit(unit),
    .amount(amount),
    .load_hour(load_hour),
    .load_minute(load_minute),
    .load_second(load_second),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hour_now(hour_now),
    .minute_now(minute_now),
    .second_now(second_now),
    .days_carried(days_carried),
    .load_error(load_error)
  );

  function automatic tda_result_t advance_clock(tod_cmd_t c);
    longint unsigned unit_secs;
    longint unsigned step_secs;
    longint unsigned now_secs;
    longint unsigned total;
    longint unsigned short_by;
    longint unsigned days;
    tda_result_t r;
    days = 0;
    r = '0;
    if (c.op == OP_LOAD) begin
      if (c.lh < HOURS_PER_DAY && c.lm < MIN_PER_HOUR && c.ls < SEC_PER_MIN) begin
        tod_hour = c.lh;
        tod_minute = c.lm;
        tod_second = c.ls;
      end else begin
        r.err = 1'b1;
      end
    end else if ((c.op == OP_ADD || c.op == OP_SUB) && c.unit != UNIT_NONE) begin
      unit_secs = (c.unit == UNIT_SEC) ? 1 : (c.unit == UNIT_MIN) ? SEC_PER_MIN : SECS_HOUR;
      step_secs = 64'(c.amount);
      step_secs = step_secs * unit_secs;
      now_secs = tod_hour * SECS_HOUR + tod_minute * SEC_PER_MIN + tod_second;
      if (c.op == OP_ADD) begin
        total = now_secs + step_secs;
        days = total / SECS_DAY;
        total = total % SECS_DAY;
      end else if (step_secs <= now_secs) begin
        total = now_secs - step_secs;
      end else begin
        short_by = step_secs - now_secs;
        days = (short_by + SECS_DAY - 1) / SECS_DAY;
        total = days * SECS_DAY - short_by;
      end
      tod_hour = 5'(total / SECS_HOUR);
      tod_minute = 6'((total / SEC_PER_MIN) % MIN_PER_HOUR);
      tod_second = 6'(total % SEC_PER_MIN);
    end
    if (days > DAYS_MAX) begin
      days = DAYS_MAX;
    end
    r.hour = tod_hour;
    r.minute = tod_minute;
    r.second = tod_second;
    r.days = days[15:0];
    return r;
  endfunction

  function automatic tod_cmd_t random_cmd();
    tod_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.op = (pick < 38) ? OP_ADD : (pick < 76) ? OP_SUB : (pick < 95) ? OP_LOAD : OP_NONE;
    c.unit = ($urandom_range(0, 19) == 0) ? UNIT_NONE : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0: c.amount = AW'($urandom_range(0, 120));
      1: c.amount = AW'($urandom_range(0, 5000));
      2: c.amount = AW'($urandom);
      3: c.amount = AW'(HOURS_PER_DAY * $urandom_range(0, 100));
      4: c.amount = AW'(SEC_PER_MIN * $urandom_range(0, 2000));
      default: c.amount = ($urandom_range(0, 1) == 0) ? AMT_MAX : AW'($urandom_range(0, 3));
    endcase
    if ($urandom_range(0, 6) == 0) begin
      c.lh = 5'($urandom);
      c.lm = 6'($urandom);
      c.ls = 6'($urandom);
    end else begin
      c.lh = 5'($urandom_range(0, HOUR_MAX));
      c.lm = 6'($urandom_range(0, MINUTE_MAX));
      c.ls = 6'($urandom_range(0, MINUTE_MAX));
    end
    return c;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 400000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int gap;
    bit quiet;
    tda_result_t want;
    quiet = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (n_words % 100 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      n_words++;
      if (pending_times.size() == 0) begin
        $error("unexpected word: %0d:%0d:%0d", hour_now, minute_now, second_now);
        n_errors++;
      end else begin
        want = pending_times.pop_front();
        check_field("hour_now", 16'(want.hour), 16'(hour_now));
        check_field("minute_now", 16'(want.minute), 16'(minute_now));
        check_field("second_now", 16'(want.second), 16'(second_now));
        check_field("days_carried", want.days, days_carried);
        check_field("load_error", 16'(want.err), 16'(load_error));
      end
    end
  end

  initial begin
    tod_cmd_t cmd;
    tda_result_t want;
    int gap;
    bit quiet;
    tod_hour = '0;
    tod_minute = '0;
    tod_second = '0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIR + N_RAND; i++) begin
      cmd = (i < N_DIR) ? steps_table[i].cmd : random_cmd();
      if (i % 128 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      operation <= cmd.op;
      unit <= cmd.unit;
      amount <= cmd.amount;
      load_hour <= cmd.lh;
      load_minute <= cmd.lm;
      load_second <= cmd.ls;
      do @(posedge clk); while (in_stall !== 1'b0);
      want = advance_clock(cmd);
      if (i < N_DIR && steps_table[i].typed) begin
        want = steps_table[i].want;
      end
      pending_times.push_back(want);
      case (cmd.op)
        OP_ADD: n_add++;
        OP_SUB: n_sub++;
        OP_LOAD: n_load++;
        default: n_other++;
      endcase
      if (want.err) n_refused++;
      if (want.days != 0) n_day_moves++;
    end
    in_valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Sent %0d adds, %0d subtracts, %0d loads (%0d refused), %0d unused codes.",
             n_add, n_sub, n_load, n_refused, n_other);
    $display("Took %0d result words, %0d of them crossing midnight.", n_words, n_day_moves);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
